// File: hdl/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types and codes for the partitioned Bloom filter.
// ----------------------------------------------------------------------------
package pbf_pkg;

  // Item actions
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_TEST  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ACTIVE_SLICES = 1'b0;
  localparam logic CFG_SLICE_LOG2    = 1'b1;

  localparam int CFG_DATA_W  = 4;
  localparam int HASH_FIELDS = 4;
  localparam int HASH_W      = 32;

  localparam logic [2:0] ACTIVE_RST  = 3'd4;
  localparam logic [3:0] LOG2_RST    = 4'd10;
  localparam logic [3:0] MIN_LOG2    = 4'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } pbf_state_e;

endpackage

// File: hdl/pbf_ram.sv
// ----------------------------------------------------------------------------
// pbf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pbf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pbf_idx.sv
// ----------------------------------------------------------------------------
// pbf_idx
// Maps one hash word and its step number to a byte address and bit lane
// of the flat bit store.
// ----------------------------------------------------------------------------
module pbf_idx
  import pbf_pkg::*;
#(
  parameter int ADDR_W = 9
) (
  input  logic [2:0]        num_slices_i,
  input  logic [3:0]        width_log2_i,
  input  logic [1:0]        step_i,
  input  logic [HASH_W-1:0] hash_i,
  output logic [ADDR_W-1:0] byte_addr_o,
  output logic [2:0]        bit_sel_o
);

  localparam int BA_W = ADDR_W + 3;

  logic [2:0]      slice;
  logic [BA_W-1:0] base;
  logic [BA_W-1:0] mask;
  logic [BA_W-1:0] bit_addr;

  // hash j lands in slice n-1-j
  assign slice    = num_slices_i - 3'd1 - {1'b0, step_i};
  assign base     = {{(BA_W-2){1'b0}}, slice[1:0]} << width_log2_i;
  assign mask     = ~({BA_W{1'b1}} << width_log2_i);
  assign bit_addr = base | (hash_i[BA_W-1:0] & mask);

  assign byte_addr_o = bit_addr[BA_W-1:3];
  assign bit_sel_o   = bit_addr[2:0];

endmodule

// File: hdl/partitioned_bloom_filter_core.sv
// ----------------------------------------------------------------------------
// partitioned_bloom_filter_core
// Partitioned Bloom filter over a single byte-wide bit store.
// ----------------------------------------------------------------------------
// The bit store is one RAM of MAX_SLICES*SLICE_BITS/8 bytes with a
// registered read. Add and test walk the active slices one after another,
// reading one byte per cycle and, on add, writing back the previous one;
// a new item is taken only once the previous one has finished. Clear
// sweeps the RAM one byte per cycle. After reset the same sweep runs with
// in_stall_o high; configuration writes are taken throughout. An unknown
// action returns found = 0 on the cycle after it is accepted.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter_core
  import pbf_pkg::*;
#(
  parameter int MAX_SLICES = 4,
  parameter int SLICE_BITS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [HASH_W-1:0]     hash_0_i,
  input  logic [HASH_W-1:0]     hash_1_i,
  input  logic [HASH_W-1:0]     hash_2_i,
  input  logic [HASH_W-1:0]     hash_3_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o
);

  localparam int STORE_BYTES = (MAX_SLICES * SLICE_BITS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int USE_MAX     = (MAX_SLICES < HASH_FIELDS) ? MAX_SLICES : HASH_FIELDS;
  localparam int LOG2_MAX    = $clog2(SLICE_BITS + 1) - 1;

  localparam logic [2:0]        USE_MAX_C  = 3'(USE_MAX);
  localparam logic [3:0]        LOG2_MAX_C = 4'((LOG2_MAX > 15) ? 15 : LOG2_MAX);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);

  // configuration
  logic [2:0] active_q;
  logic [3:0] log2_q;
  logic [2:0] n_eff;
  logic [3:0] l_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RST;
      log2_q   <= LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_SLICES: active_q <= cfg_data_i[2:0];
        CFG_SLICE_LOG2:    log2_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = active_q;
    if (n_eff == 3'd0)     n_eff = 3'd1;
    if (n_eff > USE_MAX_C) n_eff = USE_MAX_C;
    l_eff = log2_q;
    if (l_eff < MIN_LOG2)   l_eff = MIN_LOG2;
    if (l_eff > LOG2_MAX_C) l_eff = LOG2_MAX_C;
  end

  // control and datapath registers
  pbf_state_e          state_q, state_d;
  logic [2:0]          step_q, step_d;
  logic                proc_q, proc_d;
  logic                hit_q, hit_d;
  logic                reply_q, reply_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic [1:0]          action_q, action_d;
  logic [HASH_W-1:0]   hash_q [HASH_FIELDS];
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [2:0]          bit_q, bit_d;

  logic                in_accept;
  logic                out_free;
  logic                issue;
  logic                rd_bit;
  logic [ADDR_W-1:0]   rd_addr;
  logic [2:0]          rd_bit_sel;
  logic [7:0]          rdata;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;

  assign out_free   = !(out_valid_q && out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign issue      = (step_q < n_eff);
  assign rd_bit     = rdata[bit_q];

  pbf_idx #(
    .ADDR_W (ADDR_W)
  ) u_idx (
    .num_slices_i (n_eff),
    .width_log2_i (l_eff),
    .step_i       (step_q[1:0]),
    .hash_i       (hash_q[step_q[1:0]]),
    .byte_addr_o  (rd_addr),
    .bit_sel_o    (rd_bit_sel)
  );

  pbf_ram #(
    .WIDTH  (8),
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (action_i == ACT_ADD || action_i == ACT_TEST) begin
            state_d = ST_RUN;
          end else if (action_i == ACT_CLEAR) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_RUN: begin
        if (!issue) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    step_d      = step_q;
    proc_d      = proc_q;
    hit_d       = hit_q;
    reply_d     = reply_q;
    clr_d       = clr_q;
    action_d    = action_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = rdata | (8'd1 << bit_q);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'd0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          reply_d = 1'b0;
          if (reply_q) begin
            out_valid_d = 1'b1;
            found_d     = 1'b0;
          end
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          action_d = action_i;
          step_d   = 3'd0;
          proc_d   = 1'b0;
          hit_d    = 1'b1;
          clr_d    = '0;
          if (action_i == ACT_CLEAR) begin
            reply_d = 1'b1;
          end else if (action_i != ACT_ADD && action_i != ACT_TEST) begin
            out_valid_d = 1'b1;
            found_d     = 1'b0;
          end
        end
      end
      ST_RUN: begin
        // byte for step-1 returns now; byte for step is read in parallel
        if (proc_q) begin
          ram_we = (action_q == ACT_ADD);
          hit_d  = hit_q && rd_bit;
        end
        proc_d = issue;
        addr_d = rd_addr;
        bit_d  = rd_bit_sel;
        step_d = step_q + 3'd1;
        if (!issue) begin
          out_valid_d = 1'b1;
          found_d     = (action_q == ACT_TEST) && hit_q && rd_bit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= 3'd0;
      proc_q      <= 1'b0;
      hit_q       <= 1'b0;
      reply_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      proc_q      <= proc_d;
      hit_q       <= hit_d;
      reply_q     <= reply_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    addr_q   <= addr_d;
    bit_q    <= bit_d;
    found_q  <= found_d;
    if (in_accept) begin
      hash_q[0] <= hash_0_i;
      hash_q[1] <= hash_1_i;
      hash_q[2] <= hash_2_i;
      hash_q[3] <= hash_3_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

endmodule
